// File: rtl/tpue_pkg.sv
package tpue_pkg;

  // Fixed field and state widths.
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW = 16;
  localparam int unsigned IpLenW = 6;

  // Default capture limit in bytes.
  localparam int unsigned DefaultMaxFrameBytes = 65535;

  // Frame offsets of the header fields that set the payload start.
  localparam logic [PosW-1:0] IpHeaderPos = 16'd14;
  localparam logic [PosW-1:0] TcpOffsetBase = 16'd26;
  localparam logic [PosW-1:0] EthHeaderBytes = 16'd14;

  // Smallest TCP header length, in bytes, that the parser accepts.
  localparam logic [ByteW-1:0] MinTcpHeaderBytes = 8'd16;

  // Match pattern and the URL delimiter.
  localparam logic [23:0] HttpPrefix = 24'h687474;
  localparam logic [ByteW-1:0] CharH = 8'h68;
  localparam logic [ByteW-1:0] CharT = 8'h74;
  localparam logic [ByteW-1:0] CharP = 8'h70;
  localparam logic [ByteW-1:0] CharDot = 8'h2E;

  // One frame byte request.
  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic frame_last;
  } frame_t;

  // One URL result.
  typedef struct packed {
    logic [ByteW-1:0] url_byte;
    logic has_byte;
    logic url_end;
  } url_t;

endpackage

// File: rtl/tcp_payload_url_extractor_unit.sv
// Extracts the first "http" URL from the TCP payload of an Ethernet/IPv4
// frame that is fed in one byte per request, with frame_last on its final
// byte. The unit takes one frame byte per cycle unless frame_stall is
// high. Each byte is held in an input register, decoded combinationally
// against the parse state, and its results (none, one or two, or four
// when the "http" chunk matches) are written to an eight-entry result
// queue that drains one result per cycle while url_stall is low. A frame
// byte is stalled only while fewer than four queue entries are free, so a
// slow result side back-pressures the frame side. A byte's results enter
// the queue from the input register; the largest burst is four results.
module tcp_payload_url_extractor_unit #(
  parameter int unsigned MAX_FRAME_BYTES = tpue_pkg::DefaultMaxFrameBytes
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  output logic             frame_stall,
  input  tpue_pkg::frame_t frame,
  output logic             url_valid,
  input  logic             url_stall,
  output tpue_pkg::url_t   url
);

  localparam int unsigned PosW = tpue_pkg::PosW;
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FRAME_BYTES);
  localparam logic [PosW:0] MaxLim = (PosW + 1)'(MAX_FRAME_BYTES);
  localparam int unsigned QDepth = 8;
  localparam int unsigned QPtrW = 3;
  localparam logic [QPtrW:0] QRoomLimit = 4'd4;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_SCAN,
    MODE_EMIT,
    MODE_DONE
  } mode_t;

  // Input holding register.
  logic             hold_valid;
  tpue_pkg::frame_t hold;

  // Parse state.
  logic [PosW-1:0]             byte_position;
  logic [tpue_pkg::IpLenW-1:0] ip_header_bytes;
  logic [PosW-1:0]             payload_start;
  logic [23:0]                 chunk_shift;
  mode_t                       parse_mode;
  logic                        seen_one_dot;

  logic [PosW-1:0]             byte_position_next;
  logic [tpue_pkg::IpLenW-1:0] ip_header_bytes_next;
  logic [PosW-1:0]             payload_start_next;
  logic [23:0]                 chunk_shift_next;
  mode_t                       parse_mode_next;
  logic                        seen_one_dot_next;

  // Result queue.
  tpue_pkg::url_t   queue [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   count;

  tpue_pkg::url_t res [4];
  logic [2:0]     nres;

  logic advance;
  logic deq;
  logic take;

  logic [tpue_pkg::ByteW-1:0] b;
  logic                       last;
  logic [PosW-1:0]            off;
  logic [tpue_pkg::ByteW-1:0] tcp_bytes;
  logic [PosW-1:0]            tcp_pos;

  assign advance = hold_valid && (count <= QRoomLimit);
  assign frame_stall = hold_valid && (count > QRoomLimit);
  assign take = frame_valid && !frame_stall;
  assign url_valid = (count != '0);
  assign url = queue[rd_ptr];
  assign deq = url_valid && !url_stall;

  assign b = hold.frame_byte;
  assign last = hold.frame_last;
  assign off = byte_position - payload_start;
  assign tcp_bytes = {2'b00, b[7:4], 2'b00};
  assign tcp_pos = tpue_pkg::TcpOffsetBase + PosW'(ip_header_bytes);

  // Decode one frame byte against the parse state.
  always_comb begin
    byte_position_next = byte_position;
    ip_header_bytes_next = ip_header_bytes;
    payload_start_next = payload_start;
    chunk_shift_next = chunk_shift;
    parse_mode_next = parse_mode;
    seen_one_dot_next = seen_one_dot;
    nres = 3'd0;
    for (int k = 0; k < 4; k++) begin
      res[k] = '0;
    end

    if (byte_position >= MaxPos) begin
      // Past the capture limit: close any URL in progress.
      if (parse_mode == MODE_EMIT) begin
        res[0].url_end = 1'b1;
        nres = 3'd1;
        parse_mode_next = MODE_DONE;
      end
    end else begin
      case (parse_mode)
        MODE_HEADER: begin
          if (byte_position == tpue_pkg::IpHeaderPos) begin
            ip_header_bytes_next = {b[3:0], 2'b00};
          end else if (byte_position > tpue_pkg::IpHeaderPos && byte_position == tcp_pos) begin
            if (tcp_bytes < tpue_pkg::MinTcpHeaderBytes) begin
              parse_mode_next = MODE_DONE;
            end else begin
              payload_start_next = tpue_pkg::EthHeaderBytes + PosW'(ip_header_bytes)
                                   + PosW'(tcp_bytes);
              parse_mode_next = MODE_SCAN;
            end
          end
        end
        MODE_SCAN: begin
          if (byte_position >= payload_start) begin
            // A chunk counts only if a captured byte follows it.
            if (off[1:0] == 2'b11 && !last
                && ({1'b0, byte_position} + 17'd1) < MaxLim
                && chunk_shift == tpue_pkg::HttpPrefix && b == tpue_pkg::CharP) begin
              res[0] = '{url_byte: tpue_pkg::CharH, has_byte: 1'b1, url_end: 1'b0};
              res[1] = '{url_byte: tpue_pkg::CharT, has_byte: 1'b1, url_end: 1'b0};
              res[2] = '{url_byte: tpue_pkg::CharT, has_byte: 1'b1, url_end: 1'b0};
              res[3] = '{url_byte: tpue_pkg::CharP, has_byte: 1'b1, url_end: 1'b0};
              nres = 3'd4;
              seen_one_dot_next = 1'b0;
              parse_mode_next = MODE_EMIT;
            end
            chunk_shift_next = {chunk_shift[15:0], b};
          end
        end
        MODE_EMIT: begin
          if (b == tpue_pkg::CharDot && seen_one_dot) begin
            res[0].url_end = 1'b1;
            nres = 3'd1;
            parse_mode_next = MODE_DONE;
          end else begin
            if (b == tpue_pkg::CharDot) begin
              seen_one_dot_next = 1'b1;
            end
            res[0] = '{url_byte: b, has_byte: 1'b1, url_end: 1'b0};
            nres = 3'd1;
            if (last) begin
              res[1].url_end = 1'b1;
              nres = 3'd2;
              parse_mode_next = MODE_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // The position saturates at the capture limit.
    if (byte_position < MaxPos) begin
      byte_position_next = byte_position + 16'd1;
    end

    // The final byte returns the parser to its start state.
    if (last) begin
      byte_position_next = '0;
      ip_header_bytes_next = '0;
      payload_start_next = '0;
      chunk_shift_next = '0;
      parse_mode_next = MODE_HEADER;
      seen_one_dot_next = 1'b0;
    end
  end

  // Input register, parse state and result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      byte_position <= '0;
      ip_header_bytes <= '0;
      payload_start <= '0;
      chunk_shift <= '0;
      parse_mode <= MODE_HEADER;
      seen_one_dot <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (take) begin
        hold <= frame;
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end

      if (advance) begin
        byte_position <= byte_position_next;
        ip_header_bytes <= ip_header_bytes_next;
        payload_start <= payload_start_next;
        chunk_shift <= chunk_shift_next;
        parse_mode <= parse_mode_next;
        seen_one_dot <= seen_one_dot_next;
        for (int k = 0; k < 4; k++) begin
          if (3'(k) < nres) begin
            queue[wr_ptr + QPtrW'(k)] <= res[k];
          end
        end
        wr_ptr <= wr_ptr + nres;
      end

      if (deq) begin
        rd_ptr <= rd_ptr + 3'd1;
      end

      count <= count + (advance ? {1'b0, nres} : 4'd0) - {3'b000, deq};
    end
  end

endmodule
